/* src/ihq_pkg.sv */
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types and codes of the indexed min-heap queue: request and status
// codes, controller states, datapath commands and the datapath status bundle.
// ----------------------------------------------------------------------------
package ihq_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned NUM_IDS_DEF  = 256;
  localparam int unsigned KEY_BITS_DEF = 16;

  // fixed payload widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned IN_ID_W  = 8;
  localparam int unsigned IN_KEY_W = 16;
  localparam int unsigned STAT_W   = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FN_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_EXTRACT  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DECREASE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_MEMBER   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT,
    S_UP,
    S_UP_CMP,
    S_EX_TAKE,
    S_EX_LAST,
    S_DOWN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_OUT
  } state_t;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FOUND,
    OP_ABSENT,
    OP_FULL,
    OP_EMPTY,
    OP_SLOT_RD,
    OP_SLOT_POS,
    OP_INS,
    OP_ROOT_RD,
    OP_EX_TAKE,
    OP_EX_LAST,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_PLACE,
    OP_DN_RDL,
    OP_DN_L,
    OP_DN_R,
    OP_DN_MOVE
  } dp_op_t;

  // datapath status toward the controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              present;
    logic              full;
    logic              empty;
    logic              last_one;
    logic              at_root;
    logic              up_less;
    logic              l_in;
    logic              r_in;
    logic              dn_greater;
  } dp_stat_t;

endpackage

/* src/ihq_if.sv */
// ----------------------------------------------------------------------------
// ihq_if
// Valid/ready channels of the heap queue: request channel and result channel.
// ----------------------------------------------------------------------------
interface ihq_in_if;
  logic                              valid;
  logic                              ready;
  logic [ihq_pkg::FUNC_W-1:0]        func;
  logic [ihq_pkg::IN_ID_W-1:0]       item_id;
  logic [ihq_pkg::IN_KEY_W-1:0]      key;

  modport source (output valid, output func, output item_id, output key, input ready);
  modport sink   (input valid, input func, input item_id, input key, output ready);
endinterface

interface ihq_out_if;
  logic                              valid;
  logic                              ready;
  logic [ihq_pkg::IN_ID_W-1:0]       out_id;
  logic [ihq_pkg::IN_KEY_W-1:0]      out_key;
  logic                              found;
  logic [ihq_pkg::STAT_W-1:0]        status;

  modport source (output valid, output out_id, output out_key, output found,
                  output status, input ready);
  modport sink   (input valid, input out_id, input out_key, input found,
                  input status, output ready);
endinterface

/* src/ihq_ram.sv */
// ----------------------------------------------------------------------------
// ihq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ihq_ctrl.sv */
// ----------------------------------------------------------------------------
// ihq_ctrl
// Request sequencer: decodes the request, walks sift-up or sift-down one
// level per pass and hands the result to the output channel.
// ----------------------------------------------------------------------------
module ihq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  input  ihq_pkg::dp_stat_t st,
  output logic              in_ready,
  output logic              out_valid,
  output ihq_pkg::dp_op_t   op
);

  ihq_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ihq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ihq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ihq_pkg::S_DECODE;
      end
      ihq_pkg::S_DECODE: begin
        case (st.func)
          ihq_pkg::FN_MEMBER: state_nxt = ihq_pkg::S_OUT;
          ihq_pkg::FN_EXTRACT: begin
            state_nxt = st.empty ? ihq_pkg::S_OUT : ihq_pkg::S_EX_TAKE;
          end
          ihq_pkg::FN_DECREASE: begin
            state_nxt = st.present ? ihq_pkg::S_SLOT : ihq_pkg::S_OUT;
          end
          default: begin
            if (st.present)   state_nxt = ihq_pkg::S_SLOT;
            else if (st.full) state_nxt = ihq_pkg::S_OUT;
            else              state_nxt = ihq_pkg::S_UP;
          end
        endcase
      end
      ihq_pkg::S_SLOT:    state_nxt = ihq_pkg::S_UP;
      ihq_pkg::S_UP:      state_nxt = st.at_root ? ihq_pkg::S_OUT : ihq_pkg::S_UP_CMP;
      ihq_pkg::S_UP_CMP:  state_nxt = st.up_less ? ihq_pkg::S_UP : ihq_pkg::S_OUT;
      ihq_pkg::S_EX_TAKE: state_nxt = st.last_one ? ihq_pkg::S_OUT : ihq_pkg::S_EX_LAST;
      ihq_pkg::S_EX_LAST: state_nxt = ihq_pkg::S_DOWN;
      ihq_pkg::S_DOWN:    state_nxt = st.l_in ? ihq_pkg::S_DN_L : ihq_pkg::S_OUT;
      ihq_pkg::S_DN_L:    state_nxt = st.r_in ? ihq_pkg::S_DN_R : ihq_pkg::S_DN_CMP;
      ihq_pkg::S_DN_R:    state_nxt = ihq_pkg::S_DN_CMP;
      ihq_pkg::S_DN_CMP:  state_nxt = st.dn_greater ? ihq_pkg::S_DOWN : ihq_pkg::S_OUT;
      ihq_pkg::S_OUT: begin
        if (out_ready) state_nxt = ihq_pkg::S_IDLE;
      end
      default:            state_nxt = ihq_pkg::S_IDLE;
    endcase
  end

  // command and handshake outputs
  always_comb begin
    op        = ihq_pkg::OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ihq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = ihq_pkg::OP_LOAD;
      end
      ihq_pkg::S_DECODE: begin
        case (st.func)
          ihq_pkg::FN_MEMBER:   op = ihq_pkg::OP_FOUND;
          ihq_pkg::FN_EXTRACT:  op = st.empty ? ihq_pkg::OP_EMPTY : ihq_pkg::OP_ROOT_RD;
          ihq_pkg::FN_DECREASE: op = st.present ? ihq_pkg::OP_SLOT_RD : ihq_pkg::OP_ABSENT;
          default: begin
            if (st.present)   op = ihq_pkg::OP_SLOT_RD;
            else if (st.full) op = ihq_pkg::OP_FULL;
            else              op = ihq_pkg::OP_INS;
          end
        endcase
      end
      ihq_pkg::S_SLOT:    op = ihq_pkg::OP_SLOT_POS;
      ihq_pkg::S_UP:      op = st.at_root ? ihq_pkg::OP_PLACE : ihq_pkg::OP_UP_RD;
      ihq_pkg::S_UP_CMP:  op = st.up_less ? ihq_pkg::OP_UP_MOVE : ihq_pkg::OP_PLACE;
      ihq_pkg::S_EX_TAKE: op = ihq_pkg::OP_EX_TAKE;
      ihq_pkg::S_EX_LAST: op = ihq_pkg::OP_EX_LAST;
      ihq_pkg::S_DOWN:    op = st.l_in ? ihq_pkg::OP_DN_RDL : ihq_pkg::OP_PLACE;
      ihq_pkg::S_DN_L:    op = ihq_pkg::OP_DN_L;
      ihq_pkg::S_DN_R:    op = ihq_pkg::OP_DN_R;
      ihq_pkg::S_DN_CMP:  op = st.dn_greater ? ihq_pkg::OP_DN_MOVE : ihq_pkg::OP_PLACE;
      ihq_pkg::S_OUT:     out_valid = 1'b1;
      default:            op = ihq_pkg::OP_NONE;
    endcase
  end

endmodule

/* src/ihq_dp.sv */
// ----------------------------------------------------------------------------
// ihq_dp
// Heap datapath: heap entry RAM, id-to-slot RAM, presence flops, fill count,
// the moving entry and the result registers.
// ----------------------------------------------------------------------------
module ihq_dp #(
  parameter int unsigned CAPACITY = ihq_pkg::CAPACITY_DEF,
  parameter int unsigned NUM_IDS  = ihq_pkg::NUM_IDS_DEF,
  parameter int unsigned KEY_BITS = ihq_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ihq_pkg::dp_op_t               op,
  input  logic [ihq_pkg::FUNC_W-1:0]    in_func,
  input  logic [ihq_pkg::IN_ID_W-1:0]   in_item_id,
  input  logic [ihq_pkg::IN_KEY_W-1:0]  in_key,
  output ihq_pkg::dp_stat_t             st,
  output logic [ihq_pkg::IN_ID_W-1:0]   res_id,
  output logic [ihq_pkg::IN_KEY_W-1:0]  res_key,
  output logic                          res_found,
  output logic [ihq_pkg::STAT_W-1:0]    res_status
);

  localparam int unsigned POS_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W  = $clog2(NUM_IDS);
  localparam int unsigned ENT_W = ID_W + KEY_BITS;
  localparam int unsigned IDX_W = POS_W + 2;
  localparam int unsigned ID_SPAN = 2 ** ihq_pkg::IN_ID_W;

  // id reduced modulo the id count: constant table over every input id
  logic [ID_W-1:0] id_mod_tbl [ID_SPAN];
  for (genvar g = 0; g < ID_SPAN; g++) begin : g_id_mod
    assign id_mod_tbl[g] = ID_W'(g % NUM_IDS);
  end

  logic [ihq_pkg::FUNC_W-1:0] func_r;
  logic [ID_W-1:0]            id_r;
  logic [KEY_BITS-1:0]        key_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [POS_W-1:0]           pos_r;
  logic [ID_W-1:0]            mv_id_r;
  logic [KEY_BITS-1:0]        mv_key_r;
  logic [ID_W-1:0]            c_id_r;
  logic [KEY_BITS-1:0]        c_key_r;
  logic [POS_W-1:0]           c_pos_r;
  logic [NUM_IDS-1:0]         in_heap_r;

  logic                       heap_we, heap_re;
  logic [POS_W-1:0]           heap_waddr, heap_raddr;
  logic [ENT_W-1:0]           heap_wdata, heap_rdata;
  logic                       slot_we, slot_re;
  logic [ID_W-1:0]            slot_waddr;
  logic [POS_W-1:0]           slot_wdata, slot_rdata;

  logic [ID_W-1:0]            rd_id;
  logic [KEY_BITS-1:0]        rd_key;
  logic [IDX_W-1:0]           l_idx, r_idx;
  logic [POS_W-1:0]           parent;
  logic [POS_W-1:0]           last_pos;
  logic                       right_better;

  assign rd_id    = heap_rdata[ENT_W-1:KEY_BITS];
  assign rd_key   = heap_rdata[KEY_BITS-1:0];
  assign l_idx    = {1'b0, pos_r, 1'b1};
  assign r_idx    = l_idx + IDX_W'(1);
  assign parent   = POS_W'((pos_r - POS_W'(1)) >> 1);
  assign last_pos = POS_W'(cnt_r - CNT_W'(1));
  assign right_better = c_key_r > rd_key;

  // status toward the controller
  always_comb begin
    st.func       = func_r;
    st.present    = in_heap_r[id_r];
    st.full       = cnt_r == CNT_W'(CAPACITY);
    st.empty      = cnt_r == '0;
    st.last_one   = cnt_r == CNT_W'(1);
    st.at_root    = pos_r == '0;
    st.up_less    = mv_key_r < rd_key;
    st.l_in       = l_idx < IDX_W'(cnt_r);
    st.r_in       = r_idx < IDX_W'(cnt_r);
    st.dn_greater = mv_key_r > c_key_r;
  end

  // memory port selection
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = pos_r;
    heap_wdata = {mv_id_r, mv_key_r};
    heap_re    = 1'b0;
    heap_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = mv_id_r;
    slot_wdata = pos_r;
    slot_re    = 1'b0;
    case (op)
      ihq_pkg::OP_ROOT_RD: heap_re = 1'b1;
      ihq_pkg::OP_EX_TAKE: begin
        heap_re    = 1'b1;
        heap_raddr = last_pos;
      end
      ihq_pkg::OP_UP_RD: begin
        heap_re    = 1'b1;
        heap_raddr = parent;
      end
      ihq_pkg::OP_DN_RDL: begin
        heap_re    = 1'b1;
        heap_raddr = POS_W'(l_idx);
      end
      ihq_pkg::OP_DN_L: begin
        heap_re    = st.r_in;
        heap_raddr = POS_W'(r_idx);
      end
      ihq_pkg::OP_SLOT_RD: slot_re = 1'b1;
      ihq_pkg::OP_UP_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = heap_rdata;
        slot_we    = 1'b1;
        slot_waddr = rd_id;
      end
      ihq_pkg::OP_DN_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = {c_id_r, c_key_r};
        slot_we    = 1'b1;
        slot_waddr = c_id_r;
      end
      ihq_pkg::OP_PLACE: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers: fill count and presence bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      in_heap_r <= '0;
    end else begin
      case (op)
        ihq_pkg::OP_INS: begin
          cnt_r           <= cnt_r + CNT_W'(1);
          in_heap_r[id_r] <= 1'b1;
        end
        ihq_pkg::OP_EX_TAKE: begin
          cnt_r            <= cnt_r - CNT_W'(1);
          in_heap_r[rd_id] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      ihq_pkg::OP_LOAD: begin
        func_r     <= in_func;
        id_r       <= id_mod_tbl[in_item_id];
        key_r      <= KEY_BITS'(in_key);
        res_id     <= '0;
        res_key    <= '0;
        res_found  <= 1'b0;
        res_status <= ihq_pkg::ST_OK;
      end
      ihq_pkg::OP_FOUND:  res_found  <= in_heap_r[id_r];
      ihq_pkg::OP_ABSENT: res_status <= ihq_pkg::ST_ABSENT;
      ihq_pkg::OP_FULL:   res_status <= ihq_pkg::ST_FULL;
      ihq_pkg::OP_EMPTY:  res_status <= ihq_pkg::ST_EMPTY;
      ihq_pkg::OP_SLOT_POS: begin
        pos_r    <= slot_rdata;
        mv_id_r  <= id_r;
        mv_key_r <= key_r;
      end
      ihq_pkg::OP_INS: begin
        pos_r    <= POS_W'(cnt_r);
        mv_id_r  <= id_r;
        mv_key_r <= key_r;
      end
      ihq_pkg::OP_EX_TAKE: begin
        res_id  <= ihq_pkg::IN_ID_W'(rd_id);
        res_key <= ihq_pkg::IN_KEY_W'(rd_key);
      end
      ihq_pkg::OP_EX_LAST: begin
        pos_r    <= '0;
        mv_id_r  <= rd_id;
        mv_key_r <= rd_key;
      end
      ihq_pkg::OP_UP_MOVE: pos_r <= parent;
      ihq_pkg::OP_DN_L: begin
        c_id_r  <= rd_id;
        c_key_r <= rd_key;
        c_pos_r <= POS_W'(l_idx);
      end
      ihq_pkg::OP_DN_R: begin
        if (right_better) begin
          c_id_r  <= rd_id;
          c_key_r <= rd_key;
          c_pos_r <= POS_W'(r_idx);
        end
      end
      ihq_pkg::OP_DN_MOVE: pos_r <= c_pos_r;
      default: ;
    endcase
  end

  // heap entries, id and key side by side
  ihq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .re    (heap_re),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  // heap slot of each id
  ihq_ram #(
    .WIDTH (POS_W),
    .DEPTH (NUM_IDS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (id_r),
    .rdata (slot_rdata)
  );

endmodule

/* src/indexed_min_heap_queue_unit.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_unit
// Indexed binary min-heap of (id, key) entries with insert, extract minimum,
// decrease key and membership test; one result transaction per request.
// ----------------------------------------------------------------------------
//  channel  | role   | payload
//  ---------+--------+---------------------------------------
//  in_ch    | sink   | func, item_id, key
//  out_ch   | source | out_id, out_key, found, status
//
// One request at a time; membership test and error cases go straight to the
// result. Insert climbs one level per pass from the new slot, or from the
// held slot for a held id or decrease key; extract returns the root and,
// unless it empties the heap, moves the last entry to the root and descends,
// reading one entry per cycle through the single read port of the heap RAM.
// Reset clears the fill count and presence bits; no clearing pass is needed.
// A result held by out_ch stall blocks the next request until it is taken.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_unit #(
  parameter int unsigned CAPACITY = ihq_pkg::CAPACITY_DEF,
  parameter int unsigned NUM_IDS  = ihq_pkg::NUM_IDS_DEF,
  parameter int unsigned KEY_BITS = ihq_pkg::KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ihq_in_if.sink    in_ch,
  ihq_out_if.source out_ch
);

  ihq_pkg::dp_op_t   op;
  ihq_pkg::dp_stat_t st;

  // sequencer
  ihq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .op        (op)
  );

  // heap datapath
  ihq_dp #(
    .CAPACITY (CAPACITY),
    .NUM_IDS  (NUM_IDS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .in_func    (in_ch.func),
    .in_item_id (in_ch.item_id),
    .in_key     (in_ch.key),
    .st         (st),
    .res_id     (out_ch.out_id),
    .res_key    (out_ch.out_key),
    .res_found  (out_ch.found),
    .res_status (out_ch.status)
  );

endmodule
